// ----- src/jsu_pkg.sv -----
package jsu_pkg;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [20:0] CP_REPL  = 21'h00FFFD;
    // U+FFFD as UTF-8, first byte in the low bits (EF BF BD)
    localparam logic [23:0] REPL_UTF8 = 24'hBDBFEF;
    localparam int          REPL_LEN  = 3;

    typedef struct packed {
        logic [3:0][7:0] bytes;  // bytes[0] goes out first
        logic [2:0]      len;
    } utf8_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] digit;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] b);
        hex_t r;
        r.valid = 1'b1;
        r.digit = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            r.digit = 4'(b - 8'h30);
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            r.digit = 4'(b - 8'h57);
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            r.digit = 4'(b - 8'h37);
        end
        else
        begin
            r.valid = 1'b0;
        end
        return r;
    endfunction

    function automatic utf8_t utf8_encode(input logic [20:0] cp);
        utf8_t r;
        r.bytes = '0;
        if (cp <= 21'h7F)
        begin
            r.bytes[0] = cp[7:0];
            r.len      = 3'd1;
        end
        else if (cp <= 21'h7FF)
        begin
            r.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
            r.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
            r.len      = 3'd2;
        end
        else if (cp <= 21'hFFFF)
        begin
            r.bytes[0] = 8'hE0 | {4'b0000, cp[15:12]};
            r.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
            r.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
            r.len      = 3'd3;
        end
        else
        begin
            r.bytes[0] = 8'hF0 | {5'b00000, cp[20:18]};
            r.bytes[1] = 8'h80 | {2'b00, cp[17:12]};
            r.bytes[2] = 8'h80 | {2'b00, cp[11:6]};
            r.bytes[3] = 8'h80 | {2'b00, cp[5:0]};
            r.len      = 3'd4;
        end
        return r;
    endfunction

endpackage

// ----- src/json_string_unescape_utf8_core.sv -----
// JSON string body unescaper. Raw bytes of one escaped string body enter on the
// s_ side, one per request, with s_tlast on the final byte; unescaped UTF-8 leaves
// on the m_ side. Plain bytes pass through, simple escapes map to their character,
// \uXXXX (with surrogate pairs) is decoded to UTF-8, and bad \u escapes give U+FFFD
// followed by the hex digits already seen. Each input request is decoded in the
// cycle it is accepted and its whole result run (0 to 10 bytes) lands in a result
// shift register that drains one byte per cycle while m_tready is high. Rate:
// plain text streams at one byte per clock while m_tready is high; an input that
// yields more than one byte holds s_tready low until the last of them is taken,
// as the output lane carries a single byte. A new input is taken in the same cycle
// the last byte of the previous run is taken. m_tuser marks the last byte of a run,
// m_tlast the last byte of the string. End of string resets all decoder state.
module json_string_unescape_utf8_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // string_end
    output logic [0:0] m_tuser    // [0] run_last
);
    import jsu_pkg::*;

    localparam logic [2:0] MODE_PLAIN   = 3'd0;
    localparam logic [2:0] MODE_BSLASH  = 3'd1;
    localparam logic [2:0] MODE_HEX_A   = 3'd2;
    localparam logic [2:0] MODE_HIGH    = 3'd3;
    localparam logic [2:0] MODE_HIGH_BS = 3'd4;
    localparam logic [2:0] MODE_HEX_B   = 3'd5;

    localparam logic [1:0] TAIL_NONE = 2'd0;
    localparam logic [1:0] TAIL_BYTE = 2'd1;
    localparam logic [1:0] TAIL_CP   = 2'd2;

    // decoder state
    logic [2:0]       mode_reg,  mode_next;
    logic [11:0]      accum_reg, accum_next;   // first three hex digits
    logic [1:0]       seen_reg,  seen_next;
    logic [2:0][7:0]  raw_reg,   raw_next;     // digit bytes as received
    logic [9:0]       high_reg,  high_next;    // low 10 bits of held high surrogate

    // result run buffer, byte 0 is the one on m_tdata
    logic [79:0]      run_buf_reg;
    logic [3:0]       count_reg;
    logic             end_reg;

    logic             accept;
    logic             take;
    logic [7:0]       b;
    logic             last;

    // per-path outcomes
    logic             plain_to_bs;
    logic [7:0]       esc_byte;
    logic             bs_is_u;
    hex_t             hx;
    logic             dig_ok;
    logic [15:0]      v;
    logic             v_high;
    logic             v_low;
    logic [20:0]      pair_cp;

    // run composition: n_fffd x U+FFFD, n_dig digits, then tail
    logic [1:0]       n_fffd;
    logic [1:0]       n_dig;
    logic [1:0]       tail_kind;
    logic [7:0]       tail_byte;
    logic [20:0]      tail_cp;
    utf8_t            tail_enc;
    logic [31:0]      tail_bytes;
    logic [2:0]       tail_len;
    logic [3:0]       pre_len;
    logic [3:0]       dig_end;
    logic [3:0]       run_len;
    logic [79:0]      fffd_seg;
    logic [23:0]      dig_seg;
    logic [79:0]      run_vec;

    assign b      = s_tdata;
    assign last   = s_tlast;
    assign accept = s_tvalid && s_tready;
    assign take   = m_tvalid && m_tready;

    assign s_tready = (count_reg == 4'd0) || ((count_reg == 4'd1) && m_tready);
    assign m_tvalid = (count_reg != 4'd0);
    assign m_tdata  = run_buf_reg[7:0];
    assign m_tuser  = (count_reg == 4'd1);
    assign m_tlast  = (count_reg == 4'd1) && end_reg;

    always_comb
    begin
        plain_to_bs = (b == CH_BSLASH) && !last;
        bs_is_u     = (b == CH_U);
        unique case (b)
            8'h62:   esc_byte = 8'h08;
            8'h66:   esc_byte = 8'h0C;
            8'h6E:   esc_byte = 8'h0A;
            8'h72:   esc_byte = 8'h0D;
            8'h74:   esc_byte = 8'h09;
            default: esc_byte = b;
        endcase
        hx      = hex_decode(b);
        dig_ok  = hx.valid && !(last && (seen_reg != 2'd3));
        v       = {accum_reg, hx.digit};
        v_high  = (v >= 16'hD800) && (v <= 16'hDBFF);
        v_low   = (v >= 16'hDC00) && (v <= 16'hDFFF);
        pair_cp = 21'h010000 + {1'b0, high_reg, v[9:0]};
    end

    // next state and run layout
    always_comb
    begin
        mode_next  = mode_reg;
        accum_next = accum_reg;
        seen_next  = seen_reg;
        raw_next   = raw_reg;
        high_next  = high_reg;
        n_fffd     = 2'd0;
        n_dig      = 2'd0;
        tail_kind  = TAIL_NONE;
        tail_byte  = b;
        tail_cp    = CP_REPL;

        unique case (mode_reg)
            MODE_BSLASH, MODE_HIGH_BS:
            begin
                if (mode_reg == MODE_HIGH_BS && bs_is_u && !last)
                begin
                    mode_next  = MODE_HEX_B;
                    accum_next = '0;
                    seen_next  = '0;
                end
                else
                begin
                    // lone high surrogate goes out before the escape
                    if (mode_reg == MODE_HIGH_BS)
                    begin
                        n_fffd = 2'd1;
                    end
                    mode_next = MODE_PLAIN;
                    if (bs_is_u)
                    begin
                        if (last)
                        begin
                            tail_kind = TAIL_CP;
                        end
                        else
                        begin
                            mode_next  = MODE_HEX_A;
                            accum_next = '0;
                            seen_next  = '0;
                        end
                    end
                    else
                    begin
                        tail_kind = TAIL_BYTE;
                        tail_byte = esc_byte;
                    end
                end
            end
            MODE_HEX_A, MODE_HEX_B:
            begin
                if (!dig_ok)
                begin
                    n_fffd    = (mode_reg == MODE_HEX_B) ? 2'd2 : 2'd1;
                    n_dig     = seen_reg;
                    mode_next = plain_to_bs ? MODE_BSLASH : MODE_PLAIN;
                    tail_kind = plain_to_bs ? TAIL_NONE : TAIL_BYTE;
                end
                else if (seen_reg != 2'd3)
                begin
                    raw_next[seen_reg] = b;
                    accum_next         = {accum_reg[7:0], hx.digit};
                    seen_next          = seen_reg + 2'd1;
                end
                else if (mode_reg == MODE_HEX_B && v_low)
                begin
                    mode_next = MODE_PLAIN;
                    tail_kind = TAIL_CP;
                    tail_cp   = pair_cp;
                end
                else
                begin
                    // second escape was not a low half: flush the held one
                    if (mode_reg == MODE_HEX_B)
                    begin
                        n_fffd = 2'd1;
                    end
                    mode_next = MODE_PLAIN;
                    if (v_high && !last)
                    begin
                        high_next = v[9:0];
                        mode_next = MODE_HIGH;
                    end
                    else if (v_high || v_low)
                    begin
                        tail_kind = TAIL_CP;
                    end
                    else
                    begin
                        tail_kind = TAIL_CP;
                        tail_cp   = {5'b00000, v};
                    end
                end
            end
            MODE_HIGH:
            begin
                if (plain_to_bs)
                begin
                    mode_next = MODE_HIGH_BS;
                end
                else
                begin
                    n_fffd    = 2'd1;
                    mode_next = MODE_PLAIN;
                    tail_kind = TAIL_BYTE;
                end
            end
            default:
            begin
                mode_next = plain_to_bs ? MODE_BSLASH : MODE_PLAIN;
                tail_kind = plain_to_bs ? TAIL_NONE : TAIL_BYTE;
            end
        endcase

        if (last)
        begin
            mode_next  = MODE_PLAIN;
            accum_next = '0;
            seen_next  = '0;
            raw_next   = '0;
            high_next  = '0;
        end
    end

    // pack the run into one vector
    always_comb
    begin
        tail_enc = utf8_encode(tail_cp);
        unique case (tail_kind)
            TAIL_BYTE:
            begin
                tail_bytes = {24'h000000, tail_byte};
                tail_len   = 3'd1;
            end
            TAIL_CP:
            begin
                tail_bytes = tail_enc.bytes;
                tail_len   = tail_enc.len;
            end
            default:
            begin
                tail_bytes = '0;
                tail_len   = 3'd0;
            end
        endcase

        unique case (n_fffd)
            2'd1:    fffd_seg = {56'h0, REPL_UTF8};
            2'd2:    fffd_seg = {32'h0, REPL_UTF8, REPL_UTF8};
            default: fffd_seg = '0;
        endcase

        unique case (n_dig)
            2'd1:    dig_seg = {16'h0000, raw_reg[0]};
            2'd2:    dig_seg = {8'h00, raw_reg[1], raw_reg[0]};
            2'd3:    dig_seg = raw_reg;
            default: dig_seg = '0;
        endcase

        pre_len = 4'(REPL_LEN) * {2'b00, n_fffd};
        dig_end = pre_len + {2'b00, n_dig};
        run_len = dig_end + {1'b0, tail_len};
        run_vec = fffd_seg
                | ({56'h0, dig_seg} << {pre_len, 3'b000})
                | ({48'h0, tail_bytes} << {dig_end, 3'b000});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_PLAIN;
            accum_reg <= '0;
            seen_reg  <= '0;
            raw_reg   <= '0;
            high_reg  <= '0;
            count_reg <= '0;
            end_reg   <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            accum_reg <= accum_next;
            seen_reg  <= seen_next;
            raw_reg   <= raw_next;
            high_reg  <= high_next;
            count_reg <= run_len;
            end_reg   <= last;
        end
        else if (take)
        begin
            count_reg <= count_reg - 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            run_buf_reg <= run_vec;
        end
        else if (take)
        begin
            run_buf_reg <= run_buf_reg >> 8;
        end
    end

endmodule

// ----- src/jsu_checker.sv -----
module jsu_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [0:0] m_tuser
);

    // string end is always the end of a run
    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("m_tlast without run_last");

    // final byte of a string always yields output
    a_last_gives_output: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("no result after last byte");

    // input held off while a run still has bytes behind the current one
    a_hold_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> !s_tready)
        else $error("input taken in middle of run");

    // idle output side never blocks input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("s_tready low with empty output");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output changed");

endmodule

bind json_string_unescape_utf8_core jsu_checker u_jsu_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
